// ===== design/pst_pkg.sv =====
// ----------------------------------------------------------------------------
// pst_pkg: shared types and constants of the prime square tester
// Field widths, default bitmap size, square root pipeline depth, sieve states.
// ----------------------------------------------------------------------------
package pst_pkg;

  localparam int unsigned VALUE_W        = 30;
  localparam int unsigned ROOT_W         = 15;
  localparam int unsigned REM_W          = VALUE_W;
  localparam int unsigned RES_W          = VALUE_W + 1;
  localparam int unsigned ISQRT_STAGES   = VALUE_W / 2;
  localparam int unsigned SIEVE_SIZE_DEF = 32768;

  typedef enum logic [2:0] {
    SV_FILL,
    SV_READ,
    SV_TEST,
    SV_MARK,
    SV_DONE
  } sieve_state_t;

  // Result of the square root pipeline, one per request.
  typedef struct packed {
    logic              valid;
    logic              exact;
    logic [ROOT_W-1:0] root;
  } isqrt_res_t;

endpackage

// ===== design/pst_isqrt.sv =====
// ----------------------------------------------------------------------------
// pst_isqrt: pipelined exact integer square root
// One result bit per stage, fifteen register stages, remainder kept for the
// exact-square check.
// ----------------------------------------------------------------------------
module pst_isqrt import pst_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [VALUE_W-1:0] value,
  output isqrt_res_t         res_out
);

  logic [REM_W-1:0] rem_w [ISQRT_STAGES+1];
  logic [RES_W-1:0] res_w [ISQRT_STAGES+1];
  logic             vld_w [ISQRT_STAGES+1];

  assign rem_w[0] = value;
  assign res_w[0] = '0;
  assign vld_w[0] = in_valid;

  for (genvar k = 0; k < ISQRT_STAGES; k++) begin : g_stage
    localparam logic [RES_W-1:0] BIT = RES_W'(1) << (VALUE_W - 2 - 2 * k);

    logic [RES_W-1:0] trial;
    logic             take;
    logic [REM_W-1:0] rem_next;
    logic [RES_W-1:0] res_next;
    logic [REM_W-1:0] rem;
    logic [RES_W-1:0] res;
    logic             vld;

    always_comb begin
      trial    = res_w[k] + BIT;
      take     = {1'b0, rem_w[k]} >= trial;
      rem_next = take ? rem_w[k] - trial[REM_W-1:0] : rem_w[k];
      res_next = take ? (res_w[k] >> 1) + BIT : res_w[k] >> 1;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld <= 1'b0;
      end else if (en) begin
        vld <= vld_w[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem <= rem_next;
        res <= res_next;
      end
    end

    assign rem_w[k+1] = rem;
    assign res_w[k+1] = res;
    assign vld_w[k+1] = vld;
  end

  assign res_out.valid = vld_w[ISQRT_STAGES];
  assign res_out.exact = (rem_w[ISQRT_STAGES] == '0);
  assign res_out.root  = res_w[ISQRT_STAGES][ROOT_W-1:0];

endmodule

// ===== design/pst_sieve.sv =====
// ----------------------------------------------------------------------------
// pst_sieve: primality bitmap built by the sieve of Eratosthenes
// Fills the bitmap after reset, strikes multiples of each prime, then serves
// one registered lookup per cycle while query_en is high.
// ----------------------------------------------------------------------------
module pst_sieve import pst_pkg::*; #(
  parameter int unsigned SIEVE_SIZE = SIEVE_SIZE_DEF,
  localparam int unsigned AW = $clog2(SIEVE_SIZE)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          query_en,
  input  logic [AW-1:0] query_addr,
  output logic          prime_bit,
  output logic          done
);

  localparam logic [AW-1:0] FILL_LAST = AW'(SIEVE_SIZE - 1);
  localparam logic [AW:0]   SIZE_X    = (AW + 1)'(SIEVE_SIZE);

  logic mem [SIEVE_SIZE];

  sieve_state_t state, state_next;

  logic [AW-1:0] cnt;
  logic [AW-1:0] idx;
  logic [AW:0]   sq;
  logic [AW:0]   mark;

  logic [AW:0]   sq_step;
  logic [AW:0]   mark_step;
  logic          fill_last;
  logic          sweep_over;
  logic          mark_last;

  logic          we;
  logic [AW-1:0] waddr;
  logic          wdata;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  always_comb begin
    sq_step    = sq + {idx, 1'b1};
    mark_step  = mark + {1'b0, idx};
    fill_last  = (cnt == FILL_LAST);
    sweep_over = (sq >= SIZE_X);
    mark_last  = (mark_step >= SIZE_X);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      SV_FILL: if (fill_last) state_next = SV_READ;
      SV_READ: state_next = sweep_over ? SV_DONE : SV_TEST;
      SV_TEST: state_next = prime_bit ? SV_MARK : SV_READ;
      SV_MARK: if (mark_last) state_next = SV_READ;
      SV_DONE: state_next = SV_DONE;
      default: state_next = SV_FILL;
    endcase
  end

  // outputs
  always_comb begin
    we      = 1'b0;
    waddr   = cnt;
    wdata   = 1'b0;
    rd_en   = 1'b0;
    rd_addr = idx;
    done    = 1'b0;
    case (state)
      SV_FILL: begin
        we    = 1'b1;
        wdata = (cnt > AW'(1));
      end
      SV_READ: begin
        rd_en = !sweep_over;
      end
      SV_MARK: begin
        we    = 1'b1;
        waddr = mark[AW-1:0];
      end
      SV_DONE: begin
        rd_en   = query_en;
        rd_addr = query_addr;
        done    = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SV_FILL;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == SV_FILL) begin
        cnt <= cnt + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      SV_FILL: begin
        if (fill_last) begin
          idx <= AW'(2);
          sq  <= (AW + 1)'(4);
        end
      end
      SV_TEST: begin
        if (prime_bit) begin
          mark <= sq;
        end else begin
          idx <= idx + AW'(1);
          sq  <= sq_step;
        end
      end
      SV_MARK: begin
        mark <= mark_step;
        if (mark_last) begin
          idx <= idx + AW'(1);
          sq  <= sq_step;
        end
      end
      default: begin
        mark <= mark;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      prime_bit <= mem[rd_addr];
    end
  end

endmodule

// ===== design/prime_square_tester_unit.sv =====
// ----------------------------------------------------------------------------
// prime_square_tester_unit: tests whether a value is the square of a prime
// Pipelined integer square root followed by a lookup in a sieve bitmap.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one 30-bit value per request. Output stream (m_*):
//   one result per request, in order: is_prime_square and the floor of the
//   square root of the value.
//   After reset the block builds its primality bitmap (SIEVE_SIZE entries)
//   and holds s_tready low until it is complete: a fill pass over all
//   SIEVE_SIZE entries, then a sweep that reads and tests each index and
//   strikes the multiples of each prime that it finds.
//   Throughput: one request per cycle while the skid register is empty. The
//   square root unit resolves one result bit per stage over 15 stages, one
//   more stage reads the bitmap, and the result register follows, which
//   drives m_tvalid.
//   Stall: a two-entry output buffer (result register plus skid register)
//   absorbs a stalled receiver; the whole pipeline holds while the skid
//   register is full, so nothing is dropped or repeated. s_tready depends
//   on registers only.
//   Roots at or above SIEVE_SIZE count as not prime.
// ----------------------------------------------------------------------------
module prime_square_tester_unit import pst_pkg::*; #(
  parameter int unsigned SIEVE_SIZE = SIEVE_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [29:0] value, [31:30] zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [0] is_prime_square, [15:1] root
);

  localparam int unsigned AW    = $clog2(SIEVE_SIZE);
  localparam int unsigned CMP_W = 17;

  logic       build_done;
  logic       en;
  logic       accept;
  isqrt_res_t isq;

  logic [AW+ROOT_W-1:0] root_ext;
  logic [AW-1:0]        query_addr;
  logic                 prime_bit;

  // lookup stage
  logic              lk_valid;
  logic              lk_ok;
  logic [ROOT_W-1:0] lk_root;
  logic              hit;
  logic              push;
  logic              pop;

  // output buffer
  logic              out_valid;
  logic              out_hit;
  logic [ROOT_W-1:0] out_root;
  logic              skid_valid;
  logic              skid_hit;
  logic [ROOT_W-1:0] skid_root;

  // Advance the whole pipeline whenever the skid register has room.
  assign en       = !skid_valid;
  assign s_tready = build_done && en;
  assign accept   = s_tvalid && s_tready;

  pst_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (accept),
    .value    (s_tdata[VALUE_W-1:0]),
    .res_out  (isq)
  );

  assign root_ext   = {{AW{1'b0}}, isq.root};
  assign query_addr = root_ext[AW-1:0];

  pst_sieve #(
    .SIEVE_SIZE (SIEVE_SIZE)
  ) u_sieve (
    .clk        (clk),
    .rst        (rst),
    .query_en   (en),
    .query_addr (query_addr),
    .prime_bit  (prime_bit),
    .done       (build_done)
  );

  // Lookup stage: bitmap read lands together with this register.
  always_ff @(posedge clk) begin
    if (rst) begin
      lk_valid <= 1'b0;
    end else if (en) begin
      lk_valid <= isq.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lk_root <= isq.root;
      lk_ok   <= isq.exact && ({{(CMP_W - ROOT_W){1'b0}}, isq.root} < CMP_W'(SIEVE_SIZE));
    end
  end

  assign hit  = lk_ok && prime_bit;
  assign push = en && lk_valid;
  assign pop  = out_valid && m_tready;

  // Output buffer: skid takes a result only while the result register waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_hit  <= skid_hit;
        out_root <= skid_root;
      end else begin
        out_hit  <= hit;
        out_root <= lk_root;
      end
    end else if (push) begin
      skid_hit  <= hit;
      skid_root <= lk_root;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_root, out_hit};

  // The skid register only fills behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full with empty result register");

  // No result may arrive while the skid register is occupied.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("result pushed into full output buffer");

  // Once built, the bitmap stays ready.
  a_done_sticks: assert property (@(posedge clk) disable iff (rst)
    build_done |=> build_done)
    else $error("bitmap ready dropped");

  // Zero and one are never prime.
  a_small_root_not_prime: assert property (@(posedge clk) disable iff (rst)
    (push && hit) |-> (lk_root > ROOT_W'(1)))
    else $error("root below two reported prime");

endmodule
